[design/glpd_pkg.sv]
// ----------------------------------------------------------------------------
// glpd_pkg: shared types and constants for the grid local peak detector
// Register codes, result coordinate width, the queue entry that carries the
// decisions for one pixel, and the queue status bundle.
// ----------------------------------------------------------------------------
package glpd_pkg;

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;
  localparam int CFG_SIZE_RST = 32;

  localparam int PEAK_W = 5;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS = 2'd0,
    REG_GRID_COLS = 2'd1
  } cfg_reg_t;

  // Hit bits of one pixel, in the order the results leave the block
  localparam int HITS_W   = 3;
  localparam int HIT_UP   = 0;  // cell above the pixel
  localparam int HIT_LEFT = 1;  // cell left of the pixel, last row only
  localparam int HIT_SELF = 2;  // the final pixel of the grid

  typedef struct packed {
    logic [PEAK_W-1:0] row;
    logic [PEAK_W-1:0] col;
    logic [HITS_W-1:0] hits;
  } peak_ent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[design/glpd_front.sv]
// ----------------------------------------------------------------------------
// glpd_front: pixel intake and peak classification
// Holds the grid size, the raster position and two line stores. Each accepted
// pixel is compared against its stored neighbors in the cycle it is accepted;
// pixels that decide at least one peak push one entry into the queue.
// ----------------------------------------------------------------------------
module glpd_front #(
  parameter int MAX_ROWS    = 32,
  parameter int MAX_COLS    = 32,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [VALUE_WIDTH-1:0]     in_height,
  input  logic                              cfg_valid,
  input  logic [glpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [glpd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  glpd_pkg::q_stat_t                 q_stat,
  output logic                              q_push,
  output glpd_pkg::peak_ent_t               q_ent
);
  import glpd_pkg::*;

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int ROWS_RST_LAST = (CFG_SIZE_RST > MAX_ROWS) ? MAX_ROWS - 1 : CFG_SIZE_RST - 1;
  localparam int COLS_RST_LAST = (CFG_SIZE_RST > MAX_COLS) ? MAX_COLS - 1 : CFG_SIZE_RST - 1;

  logic [RW-1:0] rows_last_r;
  logic [CW-1:0] cols_last_r;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;

  // line1 holds the most recent value of each column, line2 the one before
  logic signed [VALUE_WIDTH-1:0] line1_mem [MAX_COLS];
  logic signed [VALUE_WIDTH-1:0] line2_mem [MAX_COLS];

  logic signed [VALUE_WIDTH-1:0] up1_r;     // row-1, this column
  logic signed [VALUE_WIDTH-1:0] right_r;   // row-1, next column
  logic signed [VALUE_WIDTH-1:0] up2_r;     // row-2, this column
  logic signed [VALUE_WIDTH-1:0] left_r;    // row-1, previous column
  logic signed [VALUE_WIDTH-1:0] prev_x_r;  // this row, previous column
  logic signed [VALUE_WIDTH-1:0] prev2_x_r; // this row, two columns back

  logic          accept;
  logic          cfg_hit;
  logic          last_row, last_col;
  logic          r_ge1, r_ge2, c_ge1, c_ge2;
  logic [CW-1:0] rd_addr_right;
  logic [RW-1:0] rows_cfg_last;
  logic [CW-1:0] cols_cfg_last;
  logic [HITS_W-1:0] hits;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign cfg_hit  = cfg_valid && (cfg_index == REG_GRID_ROWS || cfg_index == REG_GRID_COLS);

  // Clamp a written size into 1..MAX and keep it as a last index
  always_comb begin
    if (cfg_data == '0) begin
      rows_cfg_last = '0;
      cols_cfg_last = '0;
    end else begin
      rows_cfg_last = (32'(cfg_data) > MAX_ROWS) ? RW'(MAX_ROWS - 1)
                                                 : RW'(cfg_data - CFG_DATA_W'(1));
      cols_cfg_last = (32'(cfg_data) > MAX_COLS) ? CW'(MAX_COLS - 1)
                                                 : CW'(cfg_data - CFG_DATA_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_last_r <= RW'(ROWS_RST_LAST);
      cols_last_r <= CW'(COLS_RST_LAST);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GRID_ROWS: rows_last_r <= rows_cfg_last;
        REG_GRID_COLS: cols_last_r <= cols_cfg_last;
        default: ;
      endcase
    end
  end

  always_comb begin
    last_row = (row_r == rows_last_r);
    last_col = (col_r == cols_last_r);
    r_ge1    = (row_r != '0);
    r_ge2    = (row_r != '0) && (row_r != RW'(1));
    c_ge1    = (col_r != '0);
    c_ge2    = (col_r != '0) && (col_r != CW'(1));

    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + RW'(1);
    end else begin
      col_nxt = col_r + CW'(1);
      row_nxt = row_r;
    end
    rd_addr_right = col_nxt + CW'(1);

    hits = '0;
    hits[HIT_UP] = r_ge1 && (up1_r >= in_height)
                   && (!r_ge2 || up1_r >= up2_r)
                   && (!c_ge1 || up1_r >= left_r)
                   && (last_col || up1_r >= right_r);
    hits[HIT_LEFT] = last_row && c_ge1 && (prev_x_r >= in_height)
                     && (!r_ge1 || prev_x_r >= left_r)
                     && (!c_ge2 || prev_x_r >= prev2_x_r);
    hits[HIT_SELF] = last_row && last_col
                     && (!c_ge1 || in_height >= prev_x_r)
                     && (!r_ge1 || in_height >= up1_r);
  end

  assign q_push     = accept && (hits != '0);
  assign q_ent.row  = PEAK_W'(row_r);
  assign q_ent.col  = PEAK_W'(col_r);
  assign q_ent.hits = hits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (cfg_hit) begin
      row_r <= '0;
      col_r <= '0;
    end else if (accept) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // Line stores: write this column, prefetch the next pixel's neighbors,
  // forward the value being written when the addresses meet
  always_ff @(posedge clk) begin
    if (accept) begin
      line1_mem[col_r] <= in_height;
      line2_mem[col_r] <= up1_r;
      up1_r     <= (col_nxt == col_r) ? in_height : line1_mem[col_nxt];
      right_r   <= (rd_addr_right == col_r) ? in_height : line1_mem[rd_addr_right];
      up2_r     <= (col_nxt == col_r) ? up1_r : line2_mem[col_nxt];
      left_r    <= up1_r;
      prev2_x_r <= prev_x_r;
      prev_x_r  <= in_height;
    end
  end

endmodule

[design/glpd_queue.sv]
// ----------------------------------------------------------------------------
// glpd_queue: short decision queue
// Small first-in first-out store between intake and result issue, so that a
// pixel with several peaks does not stall the pixel stream at once.
// ----------------------------------------------------------------------------
module glpd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  glpd_pkg::peak_ent_t push_ent,
  input  logic                pop,
  output glpd_pkg::peak_ent_t head,
  output glpd_pkg::q_stat_t   stat
);
  import glpd_pkg::*;

  peak_ent_t         ent_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign head       = ent_r[rd_ptr_r];
  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + QCNT_W'(1);
    if (pop && !push) count_nxt = count_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_ent;
  end

endmodule

[design/glpd_back.sv]
// ----------------------------------------------------------------------------
// glpd_back: result issue
// Expands the queue head into one result per hit bit, in raster order, and
// holds each result in the output register until it is taken.
// ----------------------------------------------------------------------------
module glpd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  glpd_pkg::peak_ent_t           head,
  input  glpd_pkg::q_stat_t             q_stat,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [glpd_pkg::PEAK_W-1:0]   out_peak_row,
  output logic [glpd_pkg::PEAK_W-1:0]   out_peak_col,
  output logic                          out_last_of_run
);
  import glpd_pkg::*;

  logic [HITS_W-1:0] done_r, done_nxt;
  logic [HITS_W-1:0] remain, hit_sel;
  logic              out_valid_r, out_valid_nxt;
  logic [PEAK_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic              last_r, last_nxt;
  logic              load, is_last;

  assign load   = !out_valid_r || out_ready;
  assign remain = head.hits & ~done_r;

  always_comb begin
    hit_sel = '0;
    row_nxt = row_r;
    col_nxt = col_r;
    priority if (remain[HIT_UP]) begin
      hit_sel[HIT_UP] = 1'b1;
      row_nxt = head.row - PEAK_W'(1);
      col_nxt = head.col;
    end else if (remain[HIT_LEFT]) begin
      hit_sel[HIT_LEFT] = 1'b1;
      row_nxt = head.row;
      col_nxt = head.col - PEAK_W'(1);
    end else begin
      hit_sel[HIT_SELF] = 1'b1;
      row_nxt = head.row;
      col_nxt = head.col;
    end
    is_last = ((remain & ~hit_sel) == '0);

    out_valid_nxt = out_valid_r;
    done_nxt      = done_r;
    last_nxt      = last_r;
    q_pop         = 1'b0;
    if (load) begin
      out_valid_nxt = !q_stat.empty;
      if (!q_stat.empty) begin
        last_nxt = is_last;
        // retire the entry with its final hit, else mark this hit issued
        if (is_last) begin
          q_pop    = 1'b1;
          done_nxt = '0;
        end else begin
          done_nxt = done_r | hit_sel;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      done_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      done_r      <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_stat.empty) begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_peak_row    = row_r;
  assign out_peak_col    = col_r;
  assign out_last_of_run = last_r;

endmodule

[design/grid_local_peak_detector.sv]
// ----------------------------------------------------------------------------
// grid_local_peak_detector: four-neighbor local maximum finder on a grid
// Takes grid heights in raster order and reports the coordinates of every
// cell not below any of its in-grid up, down, left and right neighbors.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | in_height
//  out     | output    | out_valid / out_ready | out_peak_row, out_peak_col, out_last_of_run
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One pixel per cycle while in_ready is high; its decisions are made in the
//  cycle it is accepted. Results leave the output register one per cycle
//  while out_ready is high, after its pixel's entry passes the queue;
//  a pixel with three results holds the output while a four-entry queue keeps
//  taking pixels. in_ready drops only while that queue is full. cfg_ready is
//  always high. Reset is synchronous; the line stores are not cleared.
// ----------------------------------------------------------------------------
module grid_local_peak_detector #(
  parameter int MAX_ROWS    = 32,
  parameter int MAX_COLS    = 32,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [VALUE_WIDTH-1:0]   in_height,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [glpd_pkg::PEAK_W-1:0]     out_peak_row,
  output logic [glpd_pkg::PEAK_W-1:0]     out_peak_col,
  output logic                            out_last_of_run,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [glpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [glpd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import glpd_pkg::*;

  peak_ent_t push_ent, head_ent;
  q_stat_t   q_stat;
  logic      q_push, q_pop;

  assign cfg_ready = 1'b1;

  glpd_front #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_height (in_height),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_ent     (push_ent)
  );

  glpd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (push_ent),
    .pop      (q_pop),
    .head     (head_ent),
    .stat     (q_stat)
  );

  glpd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head_ent),
    .q_stat          (q_stat),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_peak_row    (out_peak_row),
    .out_peak_col    (out_peak_col),
    .out_last_of_run (out_last_of_run)
  );

endmodule

[design/glpd_checker.sv]
// ----------------------------------------------------------------------------
// glpd_checker: port-level checks for the grid local peak detector
// Watches the top-level ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module glpd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [glpd_pkg::PEAK_W-1:0] out_peak_row,
  input logic [glpd_pkg::PEAK_W-1:0] out_peak_col,
  input logic                        out_last_of_run
);

  // Reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // A new burst of results needs a request taken earlier, through the queue
  a_out_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without a prior request");

  // A taken result not marked last is followed at once by its sibling
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=> out_valid)
    else $error("result run broken before its last result");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_peak_row)
      && $stable(out_peak_col) && $stable(out_last_of_run))
    else $error("stalled result changed");

endmodule

bind grid_local_peak_detector glpd_checker u_glpd_checker (.*);

[verif/tb_grid_local_peak_detector.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_local_peak_detector: self-checking bench for the grid peak finder
// Streams height grids of many shapes through the block and checks every
// reported peak against a cycle-free prediction computed when each height
// request is accepted. Both channels idle at random. One phase stalls the
// output long enough to back up the input. Grid sizes are rewritten between
// phases, sometimes in the middle of a grid.
// ----------------------------------------------------------------------------
module tb_grid_local_peak_detector;
  import glpd_pkg::*;

  localparam int VW            = 16;
  localparam int GRID_MAX      = 32;
  localparam int IDLE_PCT      = 16;
  localparam int DRAIN_CYCLES  = 16;
  localparam int HOLD_CYCLES   = 120;
  localparam int RANDOM_PIXELS = 190;
  localparam int CYCLE_LIMIT   = 300000;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam logic signed [VW-1:0] HEIGHT_MAX   = 16'sh7FFF;
  localparam logic signed [VW-1:0] HEIGHT_MIN   = 16'sh8000;

  typedef enum int {MODE_WIDE, MODE_TIES, MODE_EXTREME, MODE_HILL} fill_mode_t;

  typedef struct packed {
    logic [PEAK_W-1:0] row;
    logic [PEAK_W-1:0] col;
    logic              last;
  } peak_t;

  logic                  clk;
  logic                  rst_n           = 1'b0;
  logic                  in_valid        = 1'b0;
  logic                  in_ready;
  logic signed [VW-1:0]  in_height       = '0;
  logic                  out_valid;
  logic                  out_ready       = 1'b0;
  logic [PEAK_W-1:0]     out_peak_row;
  logic [PEAK_W-1:0]     out_peak_col;
  logic                  out_last_of_run;
  logic                  cfg_valid       = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index       = REG_GRID_ROWS;
  logic [CFG_DATA_W-1:0] cfg_data        = '0;

  // Bench controls
  logic calm        = 1'b0;
  logic rx_hold     = 1'b0;
  logic rx_hold_go  = 1'b0;

  // Prediction state: sizes, two line histories and the scan position
  logic [CFG_DATA_W-1:0] rows_cfg = 6'd32;
  logic [CFG_DATA_W-1:0] cols_cfg = 6'd32;
  logic signed [VW-1:0]  line_top [GRID_MAX];
  logic signed [VW-1:0]  line_mid [GRID_MAX];
  logic signed [VW-1:0]  mid_left;
  int                    scan_row = 0;
  int                    scan_col = 0;

  logic signed [VW-1:0] pixel_q [$];
  peak_t                peak_exp_q [$];

  int pixels_pushed = 0;
  int pixels_sent   = 0;
  int peaks_seen    = 0;
  int reg_writes    = 0;
  int fail_cnt      = 0;
  int cycle_cnt     = 0;

  grid_local_peak_detector #(
    .MAX_ROWS   (GRID_MAX),
    .MAX_COLS   (GRID_MAX),
    .VALUE_WIDTH(VW)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_height      (in_height),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_peak_row   (out_peak_row),
    .out_peak_col   (out_peak_col),
    .out_last_of_run(out_last_of_run),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_size(logic [CFG_DATA_W-1:0] v);
    if (v == 0) return 1;
    if (v > GRID_MAX) return GRID_MAX;
    return int'(v);
  endfunction

  // Work out the peaks decided by one accepted height and queue them
  function automatic void predict_pixel(logic signed [VW-1:0] x);
    int                   rows, cols, r, c, n, i;
    logic signed [VW-1:0] v;
    logic                 ok, bottom;
    peak_t                found [3];
    rows = eff_size(rows_cfg);
    cols = eff_size(cols_cfg);
    r = scan_row;
    c = scan_col;
    n = 0;
    if (r >= rows) r = 0;
    if (c >= cols) c = 0;
    bottom = (r == rows - 1);

    // cell above the input
    if (r >= 1) begin
      v = line_mid[c];
      ok = (v >= x);
      if (r >= 2 && v < line_top[c]) ok = 1'b0;
      if (c >= 1 && v < mid_left) ok = 1'b0;
      if (c + 1 < cols && v < line_mid[c+1]) ok = 1'b0;
      if (ok) begin
        found[n] = '{row: PEAK_W'(r - 1), col: PEAK_W'(c), last: 1'b0};
        n++;
      end
    end

    mid_left    = line_mid[c];
    line_top[c] = line_mid[c];
    line_mid[c] = x;

    // cell left of the input, bottom row only
    if (bottom && c >= 1) begin
      v = line_mid[c-1];
      ok = (v >= x);
      if (r >= 1 && v < line_top[c-1]) ok = 1'b0;
      if (c >= 2 && v < line_mid[c-2]) ok = 1'b0;
      if (ok) begin
        found[n] = '{row: PEAK_W'(r), col: PEAK_W'(c - 1), last: 1'b0};
        n++;
      end
    end

    // final cell of the grid judges itself
    if (bottom && c == cols - 1) begin
      ok = 1'b1;
      if (c >= 1 && x < line_mid[c-1]) ok = 1'b0;
      if (r >= 1 && x < line_top[c]) ok = 1'b0;
      if (ok) begin
        found[n] = '{row: PEAK_W'(r), col: PEAK_W'(c), last: 1'b0};
        n++;
      end
    end

    c++;
    if (c >= cols) begin
      c = 0;
      r++;
      if (r >= rows) r = 0;
    end
    scan_row = r;
    scan_col = c;

    for (i = 0; i < n; i++) begin
      if (i == n - 1) found[i].last = 1'b1;
      peak_exp_q.push_back(found[i]);
    end
  endfunction

  task automatic log_fail(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Height driver: hold a pending request until taken, else maybe pull the next
  always @(posedge clk) begin : height_driver
    logic take;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      take = in_valid && in_ready;
      if (take) begin
        predict_pixel(in_height);
        pixels_sent++;
      end
      if (in_valid && !take) begin
        // hold
      end else if (pixel_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid  <= 1'b1;
        in_height <= pixel_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Peak monitor: check each accepted result against the oldest prediction
  always @(posedge clk) begin : peak_monitor
    peak_t got, want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{row: out_peak_row, col: out_peak_col, last: out_last_of_run};
        peaks_seen++;
        if (peak_exp_q.size() == 0) begin
          log_fail($sformatf("unexpected peak row %0d col %0d last %0b",
                             got.row, got.col, got.last));
        end else begin
          want = peak_exp_q.pop_front();
          if (got.row !== want.row || got.col !== want.col || got.last !== want.last) begin
            log_fail($sformatf({"peak mismatch: expected row %0d col %0d last %0b,",
                                " got row %0d col %0d last %0b"},
                               want.row, want.col, want.last,
                               got.row, got.col, got.last));
          end
        end
      end
      out_ready <= !rx_hold && (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // Long output stall, counted here once armed
  initial begin : rx_hold_proc
    wait (rx_hold_go);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_grid_local_peak_detector NOT OK");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GRID_ROWS: begin
        rows_cfg = data;
        scan_row = 0;
        scan_col = 0;
      end
      REG_GRID_COLS: begin
        cols_cfg = data;
        scan_row = 0;
        scan_col = 0;
      end
      default: ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_grid(logic [CFG_DATA_W-1:0] nr, logic [CFG_DATA_W-1:0] nc);
    write_reg(REG_GRID_ROWS, nr);
    write_reg(REG_GRID_COLS, nc);
  endtask

  task automatic queue_pixel(logic signed [VW-1:0] h);
    pixel_q.push_back(h);
    pixels_pushed++;
  endtask

  // Wait for every request to be taken and every predicted peak to arrive
  task automatic wait_idle();
    while (pixels_sent != pixels_pushed || peak_exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [VW-1:0] random_height(fill_mode_t mode);
    case (mode)
      MODE_TIES:    return VW'(int'($urandom_range(4)) - 2);
      MODE_HILL:    return VW'(int'($urandom_range(40)) - 20);
      MODE_EXTREME: begin
        case ($urandom_range(3))
          0:       return HEIGHT_MAX;
          1:       return HEIGHT_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      default:      return VW'($urandom);
    endcase
  endfunction

  task automatic run_phase(int count, fill_mode_t mode);
    repeat (count) queue_pixel(random_height(mode));
    wait_idle();
  endtask

  initial begin : stimulus
    int                    random_pixels, cells, count, sel, which;
    logic [CFG_DATA_W-1:0] nr, nc;
    random_pixels = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Single cell grid, zero size acts as one: every height is a peak
    set_grid(6'd0, 6'd1);
    queue_pixel(HEIGHT_MAX);
    queue_pixel(HEIGHT_MIN);
    queue_pixel('0);
    queue_pixel('1);
    wait_idle();

    // 2x2: flat plateau, then opposite corners high
    set_grid(6'd2, 6'd2);
    repeat (4) queue_pixel(16'sd5);
    queue_pixel(HEIGHT_MAX);
    queue_pixel(HEIGHT_MIN);
    queue_pixel(HEIGHT_MIN);
    queue_pixel(HEIGHT_MAX);
    wait_idle();

    // Single row, then single column
    set_grid(6'd1, 6'd3);
    queue_pixel(-16'sd1);
    queue_pixel(16'sd4);
    queue_pixel(16'sd4);
    wait_idle();
    set_grid(6'd3, 6'd1);
    queue_pixel(16'sd2);
    queue_pixel(-16'sd5);
    queue_pixel(16'sd7);
    wait_idle();

    // 3x3 with a center peak; an unmapped write mid-grid must not restart it
    set_grid(6'd3, 6'd3);
    queue_pixel(16'sd1);
    queue_pixel(16'sd2);
    queue_pixel(16'sd1);
    queue_pixel(16'sd2);
    wait_idle();
    write_reg(REG_UNMAPPED, 6'd63);
    queue_pixel(16'sd9);
    queue_pixel(16'sd2);
    queue_pixel(16'sd1);
    queue_pixel(16'sd2);
    queue_pixel(16'sd1);
    wait_idle();

    // Back up the block: one peak per height while the output stalls
    set_grid(6'd1, 6'd1);
    rx_hold_go <= 1'b1;
    run_phase(40, MODE_WIDE);

    // Unstalled stretch on both sides
    calm <= 1'b1;
    set_grid(6'd8, 6'd8);
    run_phase(128, MODE_TIES);
    calm <= 1'b0;

    // Largest sizes, oversize codes clamp to the maximum
    set_grid(6'd63, 6'd2);
    run_phase(64, MODE_HILL);
    set_grid(6'd1, 6'd32);
    run_phase(32, MODE_WIDE);

    // Random grids, mostly small; some phases stop mid-grid
    while (random_pixels < RANDOM_PIXELS) begin
      sel = $urandom_range(9);
      case (sel)
        0: begin
          nr = CFG_DATA_W'($urandom_range(24, 63));
          nc = CFG_DATA_W'($urandom_range(0, 2));
        end
        1: begin
          nr = CFG_DATA_W'($urandom_range(0, 2));
          nc = CFG_DATA_W'($urandom_range(24, 63));
        end
        default: begin
          nr = CFG_DATA_W'($urandom_range(0, 6));
          nc = CFG_DATA_W'($urandom_range(0, 6));
        end
      endcase
      which = $urandom_range(3);
      if (which != 1) write_reg(REG_GRID_ROWS, nr);
      if (which != 0) write_reg(REG_GRID_COLS, nc);
      cells = eff_size(rows_cfg) * eff_size(cols_cfg);
      if ($urandom_range(4) == 0) count = $urandom_range(1, 2 * cells);
      else count = cells * $urandom_range(1, 2);
      run_phase(count, fill_mode_t'($urandom_range(3)));
      random_pixels += count;
    end

    wait_idle();
    $display("Run covered %0d heights and %0d register writes; %0d peaks checked, %0d errors",
             pixels_sent, reg_writes, peaks_seen, fail_cnt);
    $display("Shapes from 1x1 to 32 long, long output stall and an unstalled stretch");
    if (fail_cnt == 0) begin
      $display("tb_grid_local_peak_detector OK");
    end else begin
      $display("tb_grid_local_peak_detector NOT OK");
    end
    $finish;
  end

endmodule
